FILE: sv/mhpq_pkg.sv
// Shared types, widths and codes for the min-heap priority queue.
package mhpq_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int KIND_W   = 2;
  localparam int ID_W     = 16;
  localparam int PRI_W    = 16;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 7;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  // One heap entry: id in the upper half, priority in the lower half.
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
  } entry_t;

  // Finished result handed from the sequencer to the output register.
  typedef struct packed {
    logic                hit;
    logic [ID_W-1:0]     id;
    logic [PRI_W-1:0]    pri;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occ;
  } rsp_t;

endpackage

FILE: sv/mhpq_ram.sv
// Heap entry store: one write port and one registered read port.
module mhpq_ram #(
  parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rd_en,
  input  logic [$clog2(CAPACITY)-1:0]     rd_addr,
  output mhpq_pkg::entry_t                rd_data,
  input  logic                            wr_en,
  input  logic [$clog2(CAPACITY)-1:0]     wr_addr,
  input  mhpq_pkg::entry_t                wr_data
);

  mhpq_pkg::entry_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // A read of the entry being written in the same cycle returns the new data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

FILE: sv/mhpq_seq.sv
// Operation sequencer: scan, sift-up and sift-down over the heap store.
module mhpq_seq #(
  parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  logic [mhpq_pkg::KIND_W-1:0]         kind,
  input  logic [mhpq_pkg::ID_W-1:0]           entry_id,
  input  logic [mhpq_pkg::PRI_W-1:0]          priority_req,
  output logic                                done_valid,
  input  logic                                done_ready,
  output mhpq_pkg::rsp_t                      done_rsp,
  output logic                                rd_en,
  output logic [$clog2(CAPACITY)-1:0]         rd_addr,
  input  mhpq_pkg::entry_t                    rd_data,
  output logic                                wr_en,
  output logic [$clog2(CAPACITY)-1:0]         wr_addr,
  output mhpq_pkg::entry_t                    wr_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = AW + 2;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_UP       = 4'd1;
  localparam logic [3:0] S_UP_CMP   = 4'd2;
  localparam logic [3:0] S_POP_ROOT = 4'd3;
  localparam logic [3:0] S_POP_LAST = 4'd4;
  localparam logic [3:0] S_DOWN     = 4'd5;
  localparam logic [3:0] S_DOWN_L   = 4'd6;
  localparam logic [3:0] S_DOWN_R   = 4'd7;
  localparam logic [3:0] S_SCAN     = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  logic [3:0]  state, state_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] idx, idx_next;
  logic [AW-1:0] scan, scan_next;
  mhpq_pkg::entry_t cur, cur_next;
  mhpq_pkg::entry_t left, left_next;
  logic [mhpq_pkg::ID_W-1:0]  key_id, key_id_next;
  logic [mhpq_pkg::PRI_W-1:0] key_pri, key_pri_next;
  logic                           res_hit, res_hit_next;
  logic [mhpq_pkg::ID_W-1:0]      res_id, res_id_next;
  logic [mhpq_pkg::PRI_W-1:0]     res_pri, res_pri_next;
  logic [mhpq_pkg::STATUS_W-1:0]  res_status, res_status_next;

  logic [IW-1:0] lc_w, rc_w, cnt_w, idx_w, scan_w;
  logic [AW-1:0] par;
  logic          lc_in, rc_in, left_wins, right_wins;
  logic [mhpq_pkg::PRI_W-1:0] best_pri;

  assign lc_w   = IW'({idx, 1'b1});
  assign rc_w   = IW'({idx, 1'b0}) + IW'(2);
  assign cnt_w  = IW'(count);
  assign idx_w  = IW'(idx);
  assign scan_w = IW'(scan);
  assign par    = AW'((idx - AW'(1)) >> 1);
  assign lc_in  = lc_w < cnt_w;
  assign rc_in  = rc_w < cnt_w;

  // Child choice; the left child wins a tie with the right one.
  assign left_wins  = left.pri < cur.pri;
  assign best_pri   = left_wins ? left.pri : cur.pri;
  assign right_wins = rc_in && (rd_data.pri < best_pri);

  assign req_ready  = (state == S_IDLE);
  assign done_valid = (state == S_DONE);

  always_comb begin
    done_rsp.hit    = res_hit;
    done_rsp.id     = res_id;
    done_rsp.pri    = res_pri;
    done_rsp.status = res_status;
    done_rsp.occ    = mhpq_pkg::OCC_W'(count);
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    idx_next        = idx;
    scan_next       = scan;
    cur_next        = cur;
    left_next       = left;
    key_id_next     = key_id;
    key_pri_next    = key_pri;
    res_hit_next    = res_hit;
    res_id_next     = res_id;
    res_pri_next    = res_pri;
    res_status_next = res_status;
    rd_en           = 1'b0;
    rd_addr         = '0;
    wr_en           = 1'b0;
    wr_addr         = idx;
    wr_data         = cur;

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          key_id_next     = entry_id;
          key_pri_next    = priority_req;
          res_hit_next    = 1'b0;
          res_id_next     = '0;
          res_pri_next    = '0;
          res_status_next = mhpq_pkg::ST_OK;
          case (kind)
            mhpq_pkg::KIND_INSERT: begin
              if (count == CW'(CAPACITY)) begin
                res_status_next = mhpq_pkg::ST_FULL;
                state_next      = S_DONE;
              end else begin
                idx_next     = count[AW-1:0];
                cur_next.id  = entry_id;
                cur_next.pri = priority_req;
                count_next   = count + CW'(1);
                state_next   = S_UP;
              end
            end
            mhpq_pkg::KIND_POP: begin
              if (count == '0) begin
                res_status_next = mhpq_pkg::ST_EMPTY;
                state_next      = S_DONE;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = S_POP_ROOT;
              end
            end
            mhpq_pkg::KIND_UPDATE: begin
              res_status_next = mhpq_pkg::ST_NOTFOUND;
              if (count == '0) begin
                state_next = S_DONE;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                scan_next  = '0;
                state_next = S_SCAN;
              end
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (rd_data.id == key_id) begin
          res_status_next = mhpq_pkg::ST_OK;
          idx_next        = scan;
          cur_next.id     = key_id;
          cur_next.pri    = key_pri;
          if (key_pri < rd_data.pri) begin
            state_next = S_UP;
          end else if (key_pri > rd_data.pri) begin
            state_next = S_DOWN;
          end else begin
            state_next = S_DONE;
          end
        end else if (scan_w + IW'(1) >= cnt_w) begin
          state_next = S_DONE;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = scan + AW'(1);
          scan_next  = scan + AW'(1);
        end
      end

      S_UP: begin
        if (idx == '0) begin
          wr_en      = 1'b1;
          state_next = S_DONE;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = par;
          state_next = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        wr_en = 1'b1;
        if (rd_data.pri > cur.pri) begin
          wr_data    = rd_data;
          idx_next   = par;
          state_next = S_UP;
        end else begin
          state_next = S_DONE;
        end
      end

      S_POP_ROOT: begin
        res_hit_next = 1'b1;
        res_id_next  = rd_data.id;
        res_pri_next = rd_data.pri;
        rd_en        = 1'b1;
        rd_addr      = AW'(count - CW'(1));
        state_next   = S_POP_LAST;
      end

      S_POP_LAST: begin
        cur_next   = rd_data;
        count_next = count - CW'(1);
        idx_next   = '0;
        state_next = S_DOWN;
      end

      S_DOWN: begin
        if (idx_w >= cnt_w) begin
          state_next = S_DONE;
        end else if (!lc_in) begin
          wr_en      = 1'b1;
          state_next = S_DONE;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = lc_w[AW-1:0];
          state_next = S_DOWN_L;
        end
      end

      S_DOWN_L: begin
        left_next  = rd_data;
        rd_en      = 1'b1;
        rd_addr    = rc_w[AW-1:0];
        state_next = S_DOWN_R;
      end

      S_DOWN_R: begin
        wr_en = 1'b1;
        if (right_wins) begin
          wr_data    = rd_data;
          idx_next   = rc_w[AW-1:0];
          state_next = S_DOWN;
        end else if (left_wins) begin
          wr_data    = left;
          idx_next   = lc_w[AW-1:0];
          state_next = S_DOWN;
        end else begin
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        if (done_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    scan       <= scan_next;
    cur        <= cur_next;
    left       <= left_next;
    key_id     <= key_id_next;
    key_pri    <= key_pri_next;
    res_hit    <= res_hit_next;
    res_id     <= res_id_next;
    res_pri    <= res_pri_next;
    res_status <= res_status_next;
  end

endmodule

FILE: sv/min_heap_priority_queue_core.sv
// Top level of the min-heap priority queue: sequencer, entry store and result register.
//
//   Channel   Handshake               Word contents
//   --------  ----------------------  ------------------------------------------------
//   request   req_valid / req_ready   kind, entry_id, priority_req
//   response  rsp_valid / rsp_ready   out_valid, out_id, out_priority, status, occupancy
//
// One request word is worked on at a time; the entry store, with one read per cycle,
// sets the pace. An insert starts at the first free slot and moves up one level at a
// time while the parent's priority is strictly greater; a pop reads the root, then the
// last entry, and sinks that former last entry from the root past any smaller child.
// An update scans entries in order up to the first match, then sifts up or down as an
// insert or a pop would; an unchanged priority ends after the scan, and a miss scans
// every entry held.
// Rejected operations (full, empty) finish once their check is done.
// Reset clears the entry count and the control state; the store itself is not cleared,
// as only entries below the count are ever used. A waiting response word does not block
// the next request: it stays in the output register until taken.
module min_heap_priority_queue_core #(
  parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_ready,
  input  logic [mhpq_pkg::KIND_W-1:0]        kind,
  input  logic [mhpq_pkg::ID_W-1:0]          entry_id,
  input  logic [mhpq_pkg::PRI_W-1:0]         priority_req,
  output logic                               rsp_valid,
  input  logic                               rsp_ready,
  output logic                               out_valid,
  output logic [mhpq_pkg::ID_W-1:0]          out_id,
  output logic [mhpq_pkg::PRI_W-1:0]         out_priority,
  output logic [mhpq_pkg::STATUS_W-1:0]      status,
  output logic [mhpq_pkg::OCC_W-1:0]         occupancy
);

  localparam int AW = $clog2(CAPACITY);

  logic              done_valid;
  logic              done_ready;
  mhpq_pkg::rsp_t    done_rsp;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  mhpq_pkg::entry_t  rd_data;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  mhpq_pkg::entry_t  wr_data;

  mhpq_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .kind         (kind),
    .entry_id     (entry_id),
    .priority_req (priority_req),
    .done_valid   (done_valid),
    .done_ready   (done_ready),
    .done_rsp     (done_rsp),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data)
  );

  mhpq_ram #(
    .CAPACITY (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // The output register takes a finished word whenever it is empty or being emptied.
  assign done_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done_valid && done_ready) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_valid && done_ready) begin
      out_valid    <= done_rsp.hit;
      out_id       <= done_rsp.id;
      out_priority <= done_rsp.pri;
      status       <= done_rsp.status;
      occupancy    <= done_rsp.occ;
    end
  end

endmodule

FILE: tb/tb_min_heap_priority_queue_core.sv
// Self-checking testbench for the min-heap priority queue core, with a shadow heap as predictor.
module tb_min_heap_priority_queue_core;

  localparam int HEAP_CAP    = mhpq_pkg::CAPACITY_DEF;
  localparam int RANDOM_GOAL = 550;
  localparam int HOLD_CYCLES = 300;   // one long hold-off on the response side
  localparam int QUIET_LIMIT = 2000;  // cycles without any accepted word
  localparam int TAIL_CYCLES = 60;
  localparam int MAX_REPORTS = 10;

  // The kind encoding left unused by the block; it must behave as a no-op.
  localparam logic [mhpq_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;

  typedef struct {
    logic [mhpq_pkg::KIND_W-1:0] kind;
    logic [mhpq_pkg::ID_W-1:0]   id;
    logic [mhpq_pkg::PRI_W-1:0]  pri;
    int                          gap;
  } req_word_t;

  logic                          clk;
  logic                          rst          = 1'b1;
  logic                          req_valid    = 1'b0;
  logic                          req_ready;
  logic [mhpq_pkg::KIND_W-1:0]   kind         = '0;
  logic [mhpq_pkg::ID_W-1:0]     entry_id     = '0;
  logic [mhpq_pkg::PRI_W-1:0]    priority_req = '0;
  logic                          rsp_valid;
  logic                          rsp_ready    = 1'b0;
  logic                          out_valid;
  logic [mhpq_pkg::ID_W-1:0]     out_id;
  logic [mhpq_pkg::PRI_W-1:0]    out_priority;
  logic [mhpq_pkg::STATUS_W-1:0] status;
  logic [mhpq_pkg::OCC_W-1:0]    occupancy;

  min_heap_priority_queue_core #(
    .CAPACITY(HEAP_CAP)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .kind        (kind),
    .entry_id    (entry_id),
    .priority_req(priority_req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .out_valid   (out_valid),
    .out_id      (out_id),
    .out_priority(out_priority),
    .status      (status),
    .occupancy   (occupancy)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Request words waiting to be offered, and response words still owed by the block.
  req_word_t      req_words[$];
  mhpq_pkg::rsp_t due_words[$];

  int words_total;
  int words_taken;
  int rsp_taken;
  int fault_count;
  int fill_level;   // occupancy as tracked while the stimulus is being built

  // ---------------------------------------------------------------------------
  // Shadow heap: an independent copy of the entry store and its count, updated
  // as each request word is accepted.
  // ---------------------------------------------------------------------------
  mhpq_pkg::entry_t shadow_heap[HEAP_CAP];
  int               shadow_count;

  function automatic void shadow_swap(int a, int b);
    mhpq_pkg::entry_t t;
    t              = shadow_heap[a];
    shadow_heap[a] = shadow_heap[b];
    shadow_heap[b] = t;
  endfunction

  // A parent moves down only when it is strictly greater, so equal keys keep their order.
  function automatic void shadow_rise(int idx);
    int up;
    while (idx > 0) begin
      up = (idx - 1) / 2;
      if (shadow_heap[up].pri > shadow_heap[idx].pri) begin
        shadow_swap(up, idx);
        idx = up;
      end else begin
        break;
      end
    end
  endfunction

  // On a tie between the children the left one wins.
  function automatic void shadow_sink(int idx);
    int lc;
    int rc;
    int best;
    while (idx < shadow_count) begin
      lc   = 2 * idx + 1;
      rc   = 2 * idx + 2;
      best = idx;
      if (lc < shadow_count && shadow_heap[lc].pri < shadow_heap[idx].pri) best = lc;
      if (rc < shadow_count && shadow_heap[rc].pri < shadow_heap[best].pri) best = rc;
      if (best == idx) break;
      shadow_swap(idx, best);
      idx = best;
    end
  endfunction

  function automatic mhpq_pkg::rsp_t shadow_apply(logic [mhpq_pkg::KIND_W-1:0] w_kind,
                                                  logic [mhpq_pkg::ID_W-1:0]   w_id,
                                                  logic [mhpq_pkg::PRI_W-1:0]  w_pri);
    mhpq_pkg::rsp_t             r;
    logic [mhpq_pkg::PRI_W-1:0] old_pri;
    bit                         found;
    r        = '0;
    r.status = mhpq_pkg::ST_OK;
    case (w_kind)
      mhpq_pkg::KIND_INSERT: begin
        if (shadow_count >= HEAP_CAP) begin
          r.status = mhpq_pkg::ST_FULL;
        end else begin
          shadow_heap[shadow_count] = {w_id, w_pri};
          shadow_count++;
          shadow_rise(shadow_count - 1);
        end
      end
      mhpq_pkg::KIND_POP: begin
        if (shadow_count == 0) begin
          r.status = mhpq_pkg::ST_EMPTY;
        end else begin
          r.hit = 1'b1;
          r.id  = shadow_heap[0].id;
          r.pri = shadow_heap[0].pri;
          shadow_swap(0, shadow_count - 1);
          shadow_count--;
          shadow_sink(0);
        end
      end
      mhpq_pkg::KIND_UPDATE: begin
        // Only the lowest-index entry carrying the id is touched.
        r.status = mhpq_pkg::ST_NOTFOUND;
        found    = 1'b0;
        for (int i = 0; i < shadow_count && !found; i++) begin
          if (shadow_heap[i].id == w_id) begin
            old_pri            = shadow_heap[i].pri;
            shadow_heap[i].pri = w_pri;
            if (w_pri < old_pri) shadow_rise(i);
            else if (w_pri > old_pri) shadow_sink(i);
            r.status = mhpq_pkg::ST_OK;
            found    = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    r.occ = shadow_count[mhpq_pkg::OCC_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction.
  // ---------------------------------------------------------------------------
  task automatic queue_word(logic [mhpq_pkg::KIND_W-1:0] w_kind,
                            logic [mhpq_pkg::ID_W-1:0]   w_id,
                            logic [mhpq_pkg::PRI_W-1:0]  w_pri);
    req_word_t w;
    w.kind = w_kind;
    w.id   = w_id;
    w.pri  = w_pri;
    // A stretch of back-to-back words with no gaps from the sender.
    if (req_words.size() >= 200 && req_words.size() < 280) w.gap = 0;
    else w.gap = $urandom_range(0, 4);
    req_words.insert(req_words.size(), w);
    if (w_kind == mhpq_pkg::KIND_INSERT && fill_level < HEAP_CAP) fill_level++;
    if (w_kind == mhpq_pkg::KIND_POP && fill_level > 0) fill_level--;
  endtask

  // Ids mostly come from a small pool so that updates find their targets and
  // duplicates occur; the rest span the whole field.
  function automatic logic [mhpq_pkg::ID_W-1:0] pick_id();
    logic [3:0] k;
    k = 4'($urandom_range(0, 11));
    if ($urandom_range(0, 9) < 6) return {k, 8'h00, k};
    return 16'($urandom);
  endfunction

  // Narrow priorities give plenty of ties and same-priority updates.
  function automatic logic [mhpq_pkg::PRI_W-1:0] pick_pri();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 16'($urandom_range(0, 15));
    if (r == 5) return 16'h0000;
    if (r == 6) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  task automatic random_word(int ins_pct, int pop_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) queue_word(KIND_SPARE, 16'($urandom), 16'($urandom));
    else if (r < 3 + ins_pct) queue_word(mhpq_pkg::KIND_INSERT, pick_id(), pick_pri());
    else if (r < 3 + ins_pct + pop_pct)
      queue_word(mhpq_pkg::KIND_POP, 16'($urandom), 16'($urandom));
    else queue_word(mhpq_pkg::KIND_UPDATE, pick_id(), pick_pri());
  endtask

  task automatic build_stimulus();
    int phase;
    int directed_words;
    // Directed opening: empty cases, field extremes, duplicates, ties and
    // every flavour of update, then a drain past empty.
    queue_word(mhpq_pkg::KIND_POP,    16'h0000, 16'h0000);
    queue_word(mhpq_pkg::KIND_UPDATE, 16'h0000, 16'h0001);
    queue_word(KIND_SPARE,            16'hFFFF, 16'hFFFF);
    queue_word(mhpq_pkg::KIND_INSERT, 16'hFFFF, 16'hFFFF);
    queue_word(mhpq_pkg::KIND_INSERT, 16'h0000, 16'h0000);
    queue_word(mhpq_pkg::KIND_INSERT, 16'h1234, 16'h8000);
    queue_word(mhpq_pkg::KIND_INSERT, 16'hFFFF, 16'h0001);
    queue_word(mhpq_pkg::KIND_INSERT, 16'h00A5, 16'h8000);
    queue_word(mhpq_pkg::KIND_UPDATE, 16'hFFFF, 16'h0002);
    queue_word(mhpq_pkg::KIND_UPDATE, 16'h1234, 16'h8000);
    queue_word(mhpq_pkg::KIND_UPDATE, 16'h00A5, 16'h0000);
    queue_word(mhpq_pkg::KIND_UPDATE, 16'h0000, 16'hFFFF);
    queue_word(mhpq_pkg::KIND_UPDATE, 16'h7777, 16'h0003);
    queue_word(KIND_SPARE,            16'h0000, 16'h0000);
    repeat (6) queue_word(mhpq_pkg::KIND_POP, 16'hFFFF, 16'hFFFF);
    directed_words = req_words.size();

    // Random part in phases: fill to capacity and beyond, mixed traffic,
    // drain to empty and beyond, mixed again.
    phase = 0;
    while (req_words.size() < directed_words + RANDOM_GOAL) begin
      case (phase % 4)
        0: begin
          while (fill_level < HEAP_CAP) random_word(75, 10);
          repeat (3) queue_word(mhpq_pkg::KIND_INSERT, pick_id(), pick_pri());
        end
        2: begin
          while (fill_level > 0) random_word(10, 75);
          repeat (2) queue_word(mhpq_pkg::KIND_POP, 16'($urandom), 16'($urandom));
        end
        default: repeat (60) random_word(40, 35);
      endcase
      phase++;
    end
  endtask

  task automatic note_fault(string msg);
    fault_count++;
    if (fault_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: waits each word's gap, then holds it until it is taken.
  // ---------------------------------------------------------------------------
  req_word_t staged;
  bit        word_staged;
  int        gap_left;

  always @(posedge clk) begin : drive_requests
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        due_words.insert(due_words.size(), shadow_apply(kind, entry_id, priority_req));
        words_taken++;
      end
      if (!req_valid || req_ready) begin
        if (!word_staged && req_words.size() != 0) begin
          staged      = req_words.pop_front();
          word_staged = 1'b1;
          gap_left    = staged.gap;
        end
        if (word_staged && gap_left == 0) begin
          req_valid    <= 1'b1;
          kind         <= staged.kind;
          entry_id     <= staged.id;
          priority_req <= staged.pri;
          word_staged  = 1'b0;
        end else begin
          req_valid <= 1'b0;
          if (word_staged) gap_left--;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Response monitor: random stalls per word, a stall-free stretch, and one long
  // hold-off so that the block backs up and stops taking requests.
  // ---------------------------------------------------------------------------
  int stall_left;
  int hold_left;
  bit pressure_done;

  always @(posedge clk) begin : check_responses
    mhpq_pkg::rsp_t want;
    if (rst) begin
      rsp_ready  <= 1'b0;
      stall_left = $urandom_range(0, 4);
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_taken++;
        if (due_words.size() == 0) begin
          note_fault($sformatf("response word %0d arrived with nothing outstanding",
                               rsp_taken));
        end else begin
          want = due_words.pop_front();
          if (want.hit !== out_valid || want.id !== out_id || want.pri !== out_priority ||
              want.status !== status || want.occ !== occupancy)
            note_fault($sformatf({"response word %0d: expected hit=%0b id=%h pri=%h ",
                                  "status=%0d occ=%0d, got hit=%0b id=%h pri=%h ",
                                  "status=%0d occ=%0d"},
                                 rsp_taken, want.hit, want.id, want.pri, want.status,
                                 want.occ, out_valid, out_id, out_priority, status,
                                 occupancy));
        end
        if (rsp_taken >= 300 && rsp_taken < 380) stall_left = 0;
        else stall_left = $urandom_range(0, 4);
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else if (!pressure_done && rsp_taken == 150) begin
        pressure_done = 1'b1;
        hold_left     = HOLD_CYCLES - 1;
        rsp_ready     <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // Ends the run if neither channel moves a word for too long.
  int quiet_cycles;

  always @(posedge clk) begin : watchdog
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    build_stimulus();
    words_total = req_words.size();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (words_taken < words_total) @(posedge clk);
    while (due_words.size() != 0) @(posedge clk);
    // Give a stray extra response word the chance to show up.
    repeat (TAIL_CYCLES) @(posedge clk);
    fault_count += due_words.size();
    if (fault_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
